### rtl/core/emc_pkg.sv
`default_nettype none

package emc_pkg;

    localparam int CONST_W = 44;   // widest constant: one 400-year era in milliseconds
    localparam int YEAR_W  = 18;   // full year before truncation to 12 bits

    localparam longint unsigned DAY_MS = 64'd86_400_000;

    localparam logic [CONST_W-1:0] MS_PER_SEC       = CONST_W'(64'd1_000);
    localparam logic [CONST_W-1:0] MS_PER_MIN       = CONST_W'(64'd60_000);
    localparam logic [CONST_W-1:0] MS_PER_HOUR      = CONST_W'(64'd3_600_000);
    localparam logic [CONST_W-1:0] MS_PER_DAY       = CONST_W'(DAY_MS);
    localparam logic [CONST_W-1:0] MS_PER_YEAR      = CONST_W'(64'd365 * DAY_MS);
    localparam logic [CONST_W-1:0] MS_PER_LEAP_YEAR = CONST_W'(64'd366 * DAY_MS);
    localparam logic [CONST_W-1:0] MS_PER_ERA       = CONST_W'(64'd146_097 * DAY_MS);

    localparam logic [YEAR_W-1:0] YEAR_BASE  = YEAR_W'(1970);
    localparam logic [YEAR_W-1:0] ERA_YEARS  = YEAR_W'(400);
    // 1970 mod 400 and mod 100, the phase of the leap counters at an era start
    localparam logic [8:0]        Y400_INIT  = 9'd370;
    localparam logic [6:0]        Y100_INIT  = 7'd70;
    localparam logic [8:0]        Y400_LAST  = 9'd399;
    localparam logic [6:0]        Y100_LAST  = 7'd99;
    localparam logic [4:0]        ZONE_RESET = 5'sd8;

    localparam logic [3:0]        MONTH_JAN  = 4'd1;
    localparam logic [3:0]        MONTH_FEB  = 4'd2;
    localparam logic [3:0]        MONTH_APR  = 4'd4;
    localparam logic [3:0]        MONTH_JUN  = 4'd6;
    localparam logic [3:0]        MONTH_SEP  = 4'd9;
    localparam logic [3:0]        MONTH_NOV  = 4'd11;
    localparam logic [3:0]        MONTH_DEC  = 4'd12;

    typedef enum logic [2:0] {
        OP_ERA,
        OP_YEAR,
        OP_MONTH,
        OP_DAY,
        OP_HOUR,
        OP_MIN,
        OP_SEC
    } t_div_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERA,
        S_YEAR,
        S_MONTH,
        S_DAY,
        S_HOUR,
        S_MIN,
        S_SEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    step;
        t_div_op op;
        logic    out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic take;
        logic out_free;
    } t_dp_status;

    function automatic logic is_leap(input logic [8:0] y400, input logic [6:0] y100);
        return (y400 == '0) || ((y100 != '0) && (y400[1:0] == 2'd0));
    endfunction

    function automatic logic [CONST_W-1:0] month_ms(input logic [3:0] month,
                                                    input logic leap);
        logic [CONST_W-1:0] len;
        unique case (month) inside
            MONTH_FEB: begin
                len = leap ? CONST_W'(64'd29 * DAY_MS) : CONST_W'(64'd28 * DAY_MS);
            end
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
                len = CONST_W'(64'd30 * DAY_MS);
            end
            default: begin
                len = CONST_W'(64'd31 * DAY_MS);
            end
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

### rtl/core/emc_div.sv
`default_nettype none

// division by repeated subtraction: each step takes one more multiple of the
// selected constant off the remainder; the caller counts the steps
module emc_div #(
    parameter int W = 44
) (
    input  wire logic         i_clk,
    input  wire logic         i_load,
    input  wire logic [W-1:0] i_value,
    input  wire logic         i_step,
    input  wire logic [W-1:0] i_sub,
    output logic              o_ge,
    output logic [9:0]        o_ms      // what is left below one second
);

    logic [W-1:0] r_rem, n_rem;

    assign o_ge = (r_rem >= i_sub);

    always_comb begin
        n_rem = r_rem;
        if (i_load) begin
            n_rem = i_value;
        end else if (i_step) begin
            n_rem = r_rem - i_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
    end

    assign o_ms = r_rem[9:0];

endmodule

`default_nettype wire

### rtl/core/emc_dp.sv
`default_nettype none

module emc_dp
    import emc_pkg::*;
#(
    parameter int MS_BITS = 44
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_ctrl_cmd          i_cmd,
    output t_dp_status              o_sts,
    input  wire logic [MS_BITS-1:0] i_epoch_ms,
    input  wire logic               i_cfg_we,
    input  wire logic [4:0]         i_cfg_wdata,
    input  wire logic               i_m_tready,
    output logic                    o_m_tvalid,
    output logic [47:0]             o_m_tdata
);

    localparam int W = (MS_BITS > CONST_W) ? MS_BITS : CONST_W;

    logic [W-1:0]      sub;
    logic              ge;
    logic              take;
    logic [9:0]        millis;

    logic [YEAR_W-1:0] r_year;
    logic [8:0]        r_y400;
    logic [6:0]        r_y100;
    logic [3:0]        r_month;
    logic [4:0]        r_day;     // whole days into the month
    logic [4:0]        r_hour;
    logic [5:0]        r_min;
    logic [5:0]        r_sec;
    logic [4:0]        r_zone;
    logic              r_out_valid;
    logic [47:0]       r_out;

    logic              leap;
    logic [6:0]        hour_sum;
    logic [4:0]        hour_loc;
    logic [4:0]        day_out;

    assign leap = is_leap(r_y400, r_y100);

    always_comb begin
        unique case (i_cmd.op)
            OP_ERA:   sub = W'(MS_PER_ERA);
            OP_YEAR:  sub = leap ? W'(MS_PER_LEAP_YEAR) : W'(MS_PER_YEAR);
            OP_MONTH: sub = W'(month_ms(r_month, leap));
            OP_DAY:   sub = W'(MS_PER_DAY);
            OP_HOUR:  sub = W'(MS_PER_HOUR);
            OP_MIN:   sub = W'(MS_PER_MIN);
            OP_SEC:   sub = W'(MS_PER_SEC);
            default:  sub = W'(MS_PER_SEC);
        endcase
    end

    // December takes whatever days are left
    assign take = ge && !((i_cmd.op == OP_MONTH) && (r_month == MONTH_DEC));

    emc_div #(
        .W(W)
    ) u_div (
        .i_clk   (i_clk),
        .i_load  (i_cmd.load),
        .i_value (W'(i_epoch_ms)),
        .i_step  (i_cmd.step && take),
        .i_sub   (sub),
        .o_ge    (ge),
        .o_ms    (millis)
    );

    // UTC hour + offset + 24 lands in 8..62, so two conditional subtracts wrap it
    assign hour_sum = 7'(r_hour) + {{2{r_zone[4]}}, r_zone} + 7'd24;
    always_comb begin
        if (hour_sum >= 7'd48) begin
            hour_loc = 5'(hour_sum - 7'd48);
        end else if (hour_sum >= 7'd24) begin
            hour_loc = 5'(hour_sum - 7'd24);
        end else begin
            hour_loc = hour_sum[4:0];
        end
    end
    assign day_out = r_day + 5'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year  <= YEAR_BASE;
            r_y400  <= Y400_INIT;
            r_y100  <= Y100_INIT;
            r_month <= MONTH_JAN;
            r_day   <= '0;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
        end else if (i_cmd.step && take) begin
            unique case (i_cmd.op)
                OP_ERA: begin
                    r_year <= r_year + ERA_YEARS;
                end
                OP_YEAR: begin
                    r_year <= r_year + YEAR_W'(1);
                    r_y400 <= (r_y400 == Y400_LAST) ? '0 : r_y400 + 9'd1;
                    r_y100 <= (r_y100 == Y100_LAST) ? '0 : r_y100 + 7'd1;
                end
                OP_MONTH: begin
                    r_month <= r_month + 4'd1;
                end
                OP_DAY: begin
                    r_day <= r_day + 5'd1;
                end
                OP_HOUR: begin
                    r_hour <= r_hour + 5'd1;
                end
                OP_MIN: begin
                    r_min <= r_min + 6'd1;
                end
                OP_SEC: begin
                    r_sec <= r_sec + 6'd1;
                end
                default: begin
                    r_sec <= r_sec;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out <= {millis, r_sec, r_min, hour_loc, day_out, r_month, r_year[11:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone      <= ZONE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_zone <= i_cfg_wdata;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.take     = take;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule

`default_nettype wire

### rtl/core/emc_ctrl.sv
`default_nettype none

module emc_ctrl
    import emc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire t_dp_status i_sts,
    output t_ctrl_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // each phase keeps subtracting until its constant no longer fits; the month phase also stops at December
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_ERA;
                end
            end
            S_ERA: begin
                if (!i_sts.take) begin
                    n_state = S_YEAR;
                end
            end
            S_YEAR: begin
                if (!i_sts.take) begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (!i_sts.take) begin
                    n_state = S_DAY;
                end
            end
            S_DAY: begin
                if (!i_sts.take) begin
                    n_state = S_HOUR;
                end
            end
            S_HOUR: begin
                if (!i_sts.take) begin
                    n_state = S_MIN;
                end
            end
            S_MIN: begin
                if (!i_sts.take) begin
                    n_state = S_SEC;
                end
            end
            S_SEC: begin
                if (!i_sts.take) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_ERA: begin
                o_cmd.step = 1'b1;
                o_cmd.op   = OP_ERA;
            end
            S_YEAR: begin
                o_cmd.step = 1'b1;
                o_cmd.op   = OP_YEAR;
            end
            S_MONTH: begin
                o_cmd.step = 1'b1;
                o_cmd.op   = OP_MONTH;
            end
            S_DAY: begin
                o_cmd.step = 1'b1;
                o_cmd.op   = OP_DAY;
            end
            S_HOUR: begin
                o_cmd.step = 1'b1;
                o_cmd.op   = OP_HOUR;
            end
            S_MIN: begin
                o_cmd.step = 1'b1;
                o_cmd.op   = OP_MIN;
            end
            S_SEC: begin
                o_cmd.step = 1'b1;
                o_cmd.op   = OP_SEC;
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/epoch_millis_to_calendar.sv
`default_nettype none

// channel   dir  handshake                          payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  epoch_ms
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  year .. millisecond
// cfg       in   i_cfg_we                           zone_hours (signed hours, reset 8)
//
// One transaction at a time. The timestamp is worn down by repeated subtraction,
// one constant per cycle: 400-year eras, years, months, days, hours, minutes and
// seconds; each phase subtracts until its constant no longer fits, months also
// stopping at December. A new timestamp is accepted only once the previous result
// has been loaded into the output register.
// Reset clears control and sets the zone to 8. A result held by a stalled
// output waits in the output register; the next item is taken meanwhile.
module epoch_millis_to_calendar
    import emc_pkg::*;
#(
    parameter  int MS_BITS   = 44,
    localparam int S_TDATA_W = ((MS_BITS + 7) / 8) * 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,   // epoch_ms
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // year[11:0] month[15:12] day[20:16] hour[25:21] minute[31:26]
    // second[37:32] millisecond[47:38]
    output logic [47:0]               o_m_axis_tdata,
    input  wire logic                 i_cfg_we,
    input  wire logic [4:0]           i_cfg_wdata
);

    t_ctrl_cmd  cmd;
    t_dp_status sts;

    emc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    emc_dp #(
        .MS_BITS(MS_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_epoch_ms  (i_s_axis_tdata[MS_BITS-1:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata)
    );

endmodule

`default_nettype wire
